FILE: hdl/ttli_pkg.sv
// shared constants and types of the time table linear interpolator
package ttli_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int WEIGHT_BITS = 16;
	localparam int WFULL_W     = WEIGHT_BITS + 1;
	localparam int KW          = $clog2(WEIGHT_BITS) + 1;
	localparam int PROD_W      = 32 + WFULL_W;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] tstamp;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic [31:0] rng;
	} cmd_t;

endpackage

FILE: hdl/time_table_linear_interpolator_unit.sv
// top level of the time table linear interpolator
//  channel   | handshake        | beat contents
//  input     | push / full      | action, time_stamp, dir_x, dir_y, dir_z, range_in
//  result    | empty / pop      | status, out_x, out_y, out_z, out_range, out_time
// append, clear and unused codes: result in the cycle after the back end takes them
// query: prime, scan, divide, multiply, sum on a hit; prime, scan, sum on a miss
// the scan checks pairs from the top of the table down, up to count-1 of them
// the scan reads one table entry a cycle; the weight divider retires one bit a cycle
// two commands queue ahead of the back end; one result waits in the output register
// reset empties the table and both queues; no clearing pass is needed
module time_table_linear_interpolator_unit import ttli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic [63:0]        time_stamp,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [31:0]        range_in,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic [31:0]        out_range,
	output logic [63:0]        out_time
);

	cmd_t    in_cmd;
	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_pop;
	logic    res_valid;

	assign in_cmd = '{action: action, tstamp: time_stamp, dx: dir_x, dy: dir_y,
		dz: dir_z, rng: range_in};

	ttli_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_cmd    (in_cmd),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cmd_valid (cmd_valid)
	);

	ttli_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.res_valid  (res_valid),
		.res_pop    (pop),
		.res_status (status),
		.res_x      (out_x),
		.res_y      (out_y),
		.res_z      (out_z),
		.res_range  (out_range),
		.res_time   (out_time)
	);

	assign empty = !res_valid;

endmodule

FILE: hdl/ttli_front.sv
// front end: accepts input beats into a two-entry command queue
module ttli_front import ttli_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  cmd_t    in_cmd,
	output cmd_t    cmd,
	input  logic    cmd_pop,
	output logic    cmd_valid
);

	cmd_t       q_q [2];
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

FILE: hdl/ttli_back.sv
// back end: point table, top-down pair scan, weight divider, blend, result register
module ttli_back import ttli_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	output logic        res_valid,
	input  logic        res_pop,
	output logic [1:0]  res_status,
	output logic [15:0] res_x,
	output logic [15:0] res_y,
	output logic [15:0] res_z,
	output logic [31:0] res_range,
	output logic [63:0] res_time
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PRIME = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_SUM   = 3'd5;

	logic [63:0] tm_mem [TABLE_DEPTH];
	logic [47:0] dr_mem [TABLE_DEPTH];
	logic [31:0] rg_mem [TABLE_DEPTH];

	logic [63:0]        tm_rd_q;
	logic [47:0]        dr_rd_q;
	logic [31:0]        rg_rd_q;
	logic [IDX_W-1:0]   rd_addr;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   p_q;
	logic [IDX_W-1:0]   hi_q;
	logic [63:0]        t_q;
	logic [63:0]        t_hi_q;
	logic [47:0]        d_hi_q;
	logic [31:0]        r_hi_q;
	logic [47:0]        d_lo_q;
	logic [31:0]        r_lo_q;
	logic [63:0]        rem_q;
	logic [63:0]        den_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [KW-1:0]      k_q;
	logic               nf_q;
	logic [PROD_W-1:0]  prod_lo_q [4];
	logic [PROD_W-1:0]  prod_hi_q [4];

	logic               res_valid_q;
	logic [1:0]         status_q;
	logic [15:0]        ox_q, oy_q, oz_q;
	logic [31:0]        orng_q;
	logic [63:0]        otime_q;

	logic               slot_free;
	logic               take;
	logic               do_write;
	logic               hit;
	logic [63:0]        rem_sh;
	logic               sub_ok;
	logic [WFULL_W-1:0] wc;
	logic [31:0]        lo_v [4];
	logic [31:0]        hi_v [4];
	logic [PROD_W-1:0]  sum_v [4];
	logic [PROD_W-1:0]  half;

	assign slot_free = !res_valid_q || res_pop;
	assign take      = (state_q == S_IDLE) && cmd_valid && slot_free;
	assign cmd_pop   = take;
	assign do_write  = take && (cmd.action == ACT_APPEND) && (cnt_q != CNT_W'(TABLE_DEPTH));
	assign hit       = (tm_rd_q <= t_q) && (t_q < t_hi_q);
	assign rem_sh    = {rem_q[62:0], 1'b0};
	assign sub_ok    = rem_q[63] || (rem_sh >= den_q);
	assign wc        = WFULL_W'(1 << WEIGHT_BITS) - {1'b0, w_q};
	assign half      = PROD_W'(1) << (WEIGHT_BITS - 1);

	always_comb begin
		rd_addr = p_q;
		if (state_q == S_IDLE)
			rd_addr = cnt_q[IDX_W-1:0] - IDX_W'(1);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo_v[i]  = {16'd0, d_lo_q[16*i +: 16] ^ 16'h8000};
			hi_v[i]  = {16'd0, d_hi_q[16*i +: 16] ^ 16'h8000};
		end
		lo_v[3] = r_lo_q;
		hi_v[3] = r_hi_q;
		for (int i = 0; i < 4; i++)
			sum_v[i] = prod_lo_q[i] + prod_hi_q[i] + half;
	end

	// table memories
	always_ff @(posedge clk) begin
		if (do_write) begin
			tm_mem[cnt_q[IDX_W-1:0]] <= cmd.tstamp;
			dr_mem[cnt_q[IDX_W-1:0]] <= {cmd.dz, cmd.dy, cmd.dx};
			rg_mem[cnt_q[IDX_W-1:0]] <= cmd.rng;
		end
		tm_rd_q <= tm_mem[rd_addr];
		dr_rd_q <= dr_mem[rd_addr];
		rg_rd_q <= rg_mem[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q <= cmd.tstamp;
				p_q <= cnt_q[IDX_W-1:0] - IDX_W'(2);
			end
			S_PRIME: begin
				t_hi_q <= tm_rd_q;
				d_hi_q <= dr_rd_q;
				r_hi_q <= rg_rd_q;
				hi_q   <= p_q + IDX_W'(1);
				p_q    <= p_q - IDX_W'(1);
			end
			S_SCAN: begin
				if (hit) begin
					rem_q  <= t_q - tm_rd_q;
					den_q  <= t_hi_q - tm_rd_q;
					d_lo_q <= dr_rd_q;
					r_lo_q <= rg_rd_q;
					w_q    <= '0;
				end else begin
					t_hi_q <= tm_rd_q;
					d_hi_q <= dr_rd_q;
					r_hi_q <= rg_rd_q;
					hi_q   <= hi_q - IDX_W'(1);
					p_q    <= p_q - IDX_W'(1);
				end
			end
			S_DIV: begin
				if (sub_ok) begin
					rem_q <= rem_sh - den_q;
					w_q   <= {w_q[WEIGHT_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					w_q   <= {w_q[WEIGHT_BITS-2:0], 1'b0};
				end
			end
			S_MUL: begin
				for (int i = 0; i < 4; i++) begin
					prod_lo_q[i] <= PROD_W'(lo_v[i]) * PROD_W'(wc);
					prod_hi_q[i] <= PROD_W'(hi_v[i]) * PROD_W'(w_q);
				end
			end
			default: begin
			end
		endcase
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			nf_q        <= 1'b0;
			res_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
			orng_q      <= '0;
			otime_q     <= '0;
		end else begin
			if (res_pop && res_valid_q)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						status_q <= ST_DONE;
						ox_q     <= '0;
						oy_q     <= '0;
						oz_q     <= '0;
						orng_q   <= '0;
						otime_q  <= '0;
						res_valid_q <= 1'b1;
						case (cmd.action)
							ACT_APPEND: begin
								if (cnt_q == CNT_W'(TABLE_DEPTH))
									status_q <= ST_FULL;
								else
									cnt_q <= cnt_q + CNT_W'(1);
							end
							ACT_CLEAR: begin
								cnt_q <= '0;
							end
							ACT_QUERY: begin
								if (cnt_q < CNT_W'(2)) begin
									status_q <= ST_NOT_FOUND;
								end else begin
									res_valid_q <= 1'b0;
									nf_q        <= 1'b0;
									state_q     <= S_PRIME;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PRIME: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						k_q     <= '0;
						state_q <= S_DIV;
					end else if (hi_q == IDX_W'(1)) begin
						nf_q    <= 1'b1;
						state_q <= S_SUM;
					end
				end
				S_DIV: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(WEIGHT_BITS - 1))
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (nf_q) begin
							status_q <= ST_NOT_FOUND;
							ox_q     <= '0;
							oy_q     <= '0;
							oz_q     <= '0;
							orng_q   <= '0;
							otime_q  <= '0;
						end else begin
							status_q <= ST_DONE;
							ox_q     <= sum_v[0][WEIGHT_BITS +: 16] ^ 16'h8000;
							oy_q     <= sum_v[1][WEIGHT_BITS +: 16] ^ 16'h8000;
							oz_q     <= sum_v[2][WEIGHT_BITS +: 16] ^ 16'h8000;
							orng_q   <= sum_v[3][WEIGHT_BITS +: 32];
							otime_q  <= t_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign res_status = status_q;
	assign res_x      = ox_q;
	assign res_y      = oy_q;
	assign res_z      = oz_q;
	assign res_range  = orng_q;
	assign res_time   = otime_q;

endmodule

FILE: hdl/ttli_checker.sv
// port checker of the time table linear interpolator and its bind
module ttli_checker import ttli_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [15:0] out_x,
	input logic [15:0] out_y,
	input logic [15:0] out_z,
	input logic [31:0] out_range,
	input logic [63:0] out_time
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("queues not empty in reset");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_DONE || status == ST_FULL || status == ST_NOT_FOUND))
		else $error("undefined status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_DONE |-> out_x == 16'd0 && out_y == 16'd0 &&
		out_z == 16'd0 && out_range == 32'd0 && out_time == 64'd0)
		else $error("nonzero fields on failed beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(out_time))
		else $error("waiting result changed");

endmodule

bind time_table_linear_interpolator_unit ttli_checker u_chk (.*);

FILE: test/tb_top.sv
// self-checking testbench of the time table linear interpolator
module tb_top;
	import ttli_pkg::*;

	typedef struct {
		logic [1:0]  st;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [31:0] rng;
		logic [63:0] t;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [1:0]         action = ACT_APPEND;
	logic [63:0]        time_stamp = '0;
	logic signed [15:0] dir_x = '0;
	logic signed [15:0] dir_y = '0;
	logic signed [15:0] dir_z = '0;
	logic [31:0]        range_in = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [1:0]         status;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic [31:0]        out_range;
	logic [63:0]        out_time;

	cmd_t    cmd_q[$];
	result_t expected_q[$];

	logic [63:0] tab_time[TABLE_DEPTH];
	logic [15:0] tab_x[TABLE_DEPTH];
	logic [15:0] tab_y[TABLE_DEPTH];
	logic [15:0] tab_z[TABLE_DEPTH];
	logic [31:0] tab_rng[TABLE_DEPTH];
	int          tab_cnt = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int queued = 0;
	int n_hit = 0, n_miss = 0, n_full = 0, n_append = 0, n_beats = 0;
	int quiet_cycles = 0;

	time_table_linear_interpolator_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.time_stamp(time_stamp), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.range_in(range_in), .empty(empty), .pop(pop), .status(status),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_range(out_range),
		.out_time(out_time)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
		return (a * ((64'd1 << WEIGHT_BITS) - w) + b * w + (64'd1 << (WEIGHT_BITS - 1)))
			>> WEIGHT_BITS;
	endfunction

	function automatic logic [15:0] mix_dir(logic [15:0] a, logic [15:0] b, logic [63:0] w);
		logic [63:0] v;
		v = mix({48'd0, a ^ 16'h8000}, {48'd0, b ^ 16'h8000}, w);
		return v[15:0] ^ 16'h8000;
	endfunction

	function automatic result_t step_table(cmd_t c);
		result_t     res;
		logic [63:0] t0, t1, r, q, den;
		logic        carry;
		int          i, k, lo, hi;
		res = '{ST_DONE, 16'd0, 16'd0, 16'd0, 32'd0, 64'd0};
		if (c.action == ACT_APPEND) begin
			if (tab_cnt >= TABLE_DEPTH) begin
				res.st = ST_FULL;
				n_full++;
			end else begin
				tab_time[tab_cnt] = c.tstamp;
				tab_x[tab_cnt] = c.dx;
				tab_y[tab_cnt] = c.dy;
				tab_z[tab_cnt] = c.dz;
				tab_rng[tab_cnt] = c.rng;
				tab_cnt++;
				n_append++;
			end
		end else if (c.action == ACT_CLEAR) begin
			tab_cnt = 0;
		end else if (c.action == ACT_QUERY) begin
			res.st = ST_NOT_FOUND;
			for (i = tab_cnt; i > 1; i--) begin
				hi = i - 1;
				lo = i - 2;
				t0 = tab_time[lo];
				t1 = tab_time[hi];
				if (t0 <= c.tstamp && c.tstamp < t1) begin
					r = c.tstamp - t0;
					den = t1 - t0;
					q = '0;
					for (k = 0; k < WEIGHT_BITS; k++) begin
						carry = r[63];
						r = r << 1;
						q = q << 1;
						if (carry || r >= den) begin
							r = r - den;
							q[0] = 1'b1;
						end
					end
					res.st = ST_DONE;
					res.x = mix_dir(tab_x[lo], tab_x[hi], q);
					res.y = mix_dir(tab_y[lo], tab_y[hi], q);
					res.z = mix_dir(tab_z[lo], tab_z[hi], q);
					res.rng = 32'(mix({32'd0, tab_rng[lo]}, {32'd0, tab_rng[hi]}, q));
					res.t = c.tstamp;
					break;
				end
			end
			if (res.st == ST_DONE)
				n_hit++;
			else
				n_miss++;
		end
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				expected_q.push_back(step_table('{action, time_stamp, dir_x, dir_y, dir_z,
					range_in}));
				void'(cmd_q.pop_front());
			end
			if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				action <= cmd_q[0].action;
				time_stamp <= cmd_q[0].tstamp;
				dir_x <= cmd_q[0].dx;
				dir_y <= cmd_q[0].dy;
				dir_z <= cmd_q[0].dz;
				range_in <= cmd_q[0].rng;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				n_beats++;
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, status %0d", $time, status);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (status !== e.st) begin
						$display("%0t: status exp %0d got %0d", $time, e.st, status);
						errors++;
					end
					if (out_x !== e.x) begin
						$display("%0t: out_x exp %h got %h", $time, e.x, out_x);
						errors++;
					end
					if (out_y !== e.y) begin
						$display("%0t: out_y exp %h got %h", $time, e.y, out_y);
						errors++;
					end
					if (out_z !== e.z) begin
						$display("%0t: out_z exp %h got %h", $time, e.z, out_z);
						errors++;
					end
					if (out_range !== e.rng) begin
						$display("%0t: out_range exp %h got %h", $time, e.rng, out_range);
						errors++;
					end
					if (out_time !== e.t) begin
						$display("%0t: out_time exp %h got %h", $time, e.t, out_time);
						errors++;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("%0t: no progress", $time);
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] rand_dir();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_cmd(logic [1:0] a, logic [63:0] t, logic [15:0] x,
		logic [15:0] y, logic [15:0] z, logic [31:0] r);
		cmd_t c;
		c = '{a, t, x, y, z, r};
		cmd_q.push_back(c);
		queued++;
	endfunction

	function automatic void add_point(logic [63:0] t);
		add_cmd(ACT_APPEND, t, rand_dir(), rand_dir(), rand_dir(), $urandom);
	endfunction

	function automatic void add_query(logic [63:0] t);
		add_cmd(ACT_QUERY, t, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
	endfunction

	// clear, load a short track, then query it
	function automatic void add_track();
		logic [63:0] tm, d, lo, hi;
		logic [63:0] ts[$];
		int          n, k, j, nq;
		n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
		add_cmd(ACT_CLEAR, rand64(), 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom);
		tm = ($urandom_range(3) == 0) ? 64'($urandom_range(0, 100)) : rand64();
		for (k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: d = '0;
				1: d = rand64();
				2: d = 64'd1;
				default: d = {30'd0, 2'($urandom_range(0, 3)), $urandom};
			endcase
			if (k > 0)
				tm = tm + d;
			if ($urandom_range(19) == 0)
				tm = rand64();
			add_point(tm);
			ts.push_back(tm);
			if ($urandom_range(14) == 0)
				add_cmd(2'd3, rand64(), 16'($urandom), 16'($urandom), 16'($urandom),
					$urandom);
		end
		nq = $urandom_range(1, 6);
		for (k = 0; k < nq; k++) begin
			if (ts.size() >= 2 && $urandom_range(4) != 0) begin
				j = $urandom_range(0, ts.size() - 2);
				lo = ts[j];
				hi = ts[j + 1];
				case ($urandom_range(5))
					0: add_query(lo);
					1: add_query(hi - 1);
					2: add_query(hi);
					default: add_query((hi > lo) ? lo + rand64() % (hi - lo) : lo);
				endcase
			end else begin
				add_query(rand64());
			end
		end
	endfunction

	task automatic run_phase(int send_pct, int recv_pct, int n);
		int goal;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		goal = queued + n;
		while (queued < goal)
			add_track();
		while (cmd_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] tm;
		int          k, waited;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, ignored code, order faults
		add_query(64'd0);
		add_point(64'd0);
		add_query(64'd0);
		add_cmd(ACT_APPEND, 64'hffff_ffff_ffff_ffff, 16'h7fff, 16'h8000, 16'h7fff,
			32'hffff_ffff);
		add_query(64'd0);
		add_query(64'hffff_ffff_ffff_fffe);
		add_query(64'hffff_ffff_ffff_ffff);
		add_query(64'h8000_0000_0000_0000);
		add_cmd(2'd3, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
		add_cmd(ACT_CLEAR, 64'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		add_query(64'd5);
		add_cmd(ACT_APPEND, 64'd10, 16'h8000, 16'h7fff, 16'h0000, 32'd0);
		add_cmd(ACT_APPEND, 64'd10, 16'h7fff, 16'h8000, 16'hffff, 32'hffff_ffff);
		add_cmd(ACT_APPEND, 64'd13, 16'h8000, 16'h7fff, 16'h0001, 32'd1);
		add_query(64'd10);
		add_query(64'd11);
		add_point(64'd4);
		add_point(64'd8);
		add_query(64'd6);
		add_query(64'd12);
		add_cmd(ACT_CLEAR, rand64(), 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom);
		add_query(64'd11);

		// table fill up to capacity and beyond
		add_cmd(ACT_CLEAR, 64'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		tm = {32'd0, $urandom};
		for (k = 0; k < TABLE_DEPTH; k++) begin
			add_point(tm);
			tm = tm + $urandom_range(1, 100000);
		end
		add_point(tm);
		add_point(tm + 1);
		add_query(tm - 1);
		add_query(tm);
		add_query({32'd0, $urandom});
		add_query(64'd0);

		run_phase(0, 0, 100);
		run_phase(83, 0, 100);
		run_phase(0, 83, 100);
		run_phase(29, 29, 100);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (push || expected_q.size() != 0)
			@(posedge clk);
		waited = 0;
		while (waited < 40) begin
			@(posedge clk);
			waited++;
		end
		$display("items %0d, beats %0d: %0d appends, %0d table full", queued, n_beats,
			n_append, n_full);
		$display("queries: %0d interpolated, %0d with no bracketing pair", n_hit, n_miss);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

FILE: time_table_linear_interpolator_unit.f
hdl/ttli_pkg.sv
hdl/ttli_front.sv
hdl/ttli_back.sv
hdl/time_table_linear_interpolator_unit.sv
hdl/ttli_checker.sv
test/tb_top.sv
